// File: rtl/tcg_pkg.sv
`timescale 1ns / 1ps
// Shared widths, pipeline depths and types for the triangle geometry block.
package tcg_pkg;

  localparam int CoordW    = 32;
  localparam int EdgeW     = CoordW + 1;
  localparam int RefW      = 16;
  localparam int PW        = RefW + 1;
  localparam int FracBits  = 15;
  localparam int ProdW     = 2 * EdgeW;
  localparam int DiffW     = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int HalfW     = MagW / 2;
  localparam int SqW       = 2 * MagW;
  localparam int NShift    = 36;
  localparam int NW        = 96;
  localparam int RootW     = 48;
  localparam int RemW      = NW + 1;
  localparam int MapLat    = 2;
  localparam int AreaLat   = 6;
  localparam int SqrtLat   = RootW;
  localparam int TotLat    = AreaLat + SqrtLat;
  localparam int JacW      = 6 * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [PW-1:0]     pref_t;

endpackage

// File: rtl/tcg_map.sv
`timescale 1ns / 1ps
// One axis of the reference-to-global mapping: products, rounded sum, saturation.
module tcg_map (
  input  logic           clk,
  input  tcg_pkg::coord_t a_i,
  input  tcg_pkg::edge_t  e1_i,
  input  tcg_pkg::edge_t  e2_i,
  input  tcg_pkg::pref_t  pu_i,
  input  tcg_pkg::pref_t  pv_i,
  output tcg_pkg::coord_t g_o
);
  import tcg_pkg::*;

  localparam int MulW = EdgeW + PW;
  localparam int SumW = MulW + 3;
  localparam int QW   = SumW - FracBits;

  coord_t                  a_r;
  logic signed [MulW-1:0]  p1_r;
  logic signed [MulW-1:0]  p2_r;
  coord_t                  g_r;
  logic signed [SumW-1:0]  sum;
  logic signed [QW-1:0]    quo;
  coord_t                  g_nxt;

  always_ff @(posedge clk) begin
    a_r  <= a_i;
    p1_r <= MulW'(e1_i) * MulW'(pu_i);
    p2_r <= MulW'(e2_i) * MulW'(pv_i);
  end

  always_comb begin
    sum = (SumW'(a_r) <<< FracBits) + SumW'(p1_r) + SumW'(p2_r)
          + SumW'(1 << (FracBits - 1));
    quo = QW'(sum >>> FracBits);
    if (quo > QW'(64'sd2147483647)) begin
      g_nxt = 32'sh7fffffff;
    end else if (quo < -QW'(64'sd2147483648)) begin
      g_nxt = 32'sh80000000;
    end else begin
      g_nxt = CoordW'(quo);
    end
  end

  always_ff @(posedge clk) begin
    g_r <= g_nxt;
  end

  assign g_o = g_r;

endmodule

// File: rtl/tcg_area.sv
`timescale 1ns / 1ps
// Squared norm of the edge cross product, scaled for the square root.
module tcg_area (
  input  logic           clk,
  input  tcg_pkg::edge_t  f1_i,
  input  tcg_pkg::edge_t  g1_i,
  input  tcg_pkg::edge_t  h1_i,
  input  tcg_pkg::edge_t  f2_i,
  input  tcg_pkg::edge_t  g2_i,
  input  tcg_pkg::edge_t  h2_i,
  output logic [tcg_pkg::NW-1:0] n_o
);
  import tcg_pkg::*;

  logic signed [ProdW-1:0] pa_r [0:2];
  logic signed [ProdW-1:0] pb_r [0:2];
  logic signed [DiffW-1:0] d_r  [0:2];
  logic [MagW-1:0]         m_r  [0:2];
  logic [MagW-1:0]         hh_r [0:2];
  logic [MagW-1:0]         hl_r [0:2];
  logic [MagW-1:0]         ll_r [0:2];
  logic [SqW-1:0]          sq_r [0:2];
  logic [SqW-1:0]          s_r;

  always_ff @(posedge clk) begin
    pa_r[0] <= ProdW'(g1_i) * ProdW'(h2_i);
    pb_r[0] <= ProdW'(h1_i) * ProdW'(g2_i);
    pa_r[1] <= ProdW'(h1_i) * ProdW'(f2_i);
    pb_r[1] <= ProdW'(f1_i) * ProdW'(h2_i);
    pa_r[2] <= ProdW'(f1_i) * ProdW'(g2_i);
    pb_r[2] <= ProdW'(g1_i) * ProdW'(f2_i);
    for (int i = 0; i < 3; i++) begin
      d_r[i]  <= DiffW'(pa_r[i]) - DiffW'(pb_r[i]);
      m_r[i]  <= d_r[i][DiffW-1] ? MagW'(-d_r[i]) : MagW'(d_r[i]);
      hh_r[i] <= MagW'(m_r[i][MagW-1:HalfW]) * MagW'(m_r[i][MagW-1:HalfW]);
      hl_r[i] <= MagW'(m_r[i][MagW-1:HalfW]) * MagW'(m_r[i][HalfW-1:0]);
      ll_r[i] <= MagW'(m_r[i][HalfW-1:0]) * MagW'(m_r[i][HalfW-1:0]);
      sq_r[i] <= (SqW'(hh_r[i]) << (2 * HalfW)) + (SqW'(hl_r[i]) << (HalfW + 1))
                 + SqW'(ll_r[i]);
    end
    s_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  assign n_o = s_r[NShift +: NW];

endmodule

// File: rtl/tcg_sqrt.sv
`timescale 1ns / 1ps
// Pipelined bit-by-bit integer square root, one result bit per stage.
module tcg_sqrt (
  input  logic                     clk,
  input  logic [tcg_pkg::NW-1:0]   n_i,
  output logic [tcg_pkg::RootW-1:0] root_o
);
  import tcg_pkg::*;

  logic [RootW-1:0] root_r [0:SqrtLat];
  logic [RemW-1:0]  rem_r  [0:SqrtLat];

  assign root_r[0] = '0;
  assign rem_r[0]  = RemW'(n_i);

  for (genvar i = 0; i < SqrtLat; i++) begin : g_stage
    localparam int B = RootW - 1 - i;
    logic [RemW-1:0] trial;
    logic [RemW:0]   diff;

    always_comb begin
      trial = (RemW'(root_r[i]) << (B + 1)) | (RemW'(1) << (2 * B));
      diff  = {1'b0, rem_r[i]} - {1'b0, trial};
    end

    always_ff @(posedge clk) begin
      if (!diff[RemW]) begin
        rem_r[i+1]  <= diff[RemW-1:0];
        root_r[i+1] <= root_r[i] | (RootW'(1) << B);
      end else begin
        rem_r[i+1]  <= rem_r[i];
        root_r[i+1] <= root_r[i];
      end
    end
  end

  assign root_o = root_r[SqrtLat];

endmodule

// File: rtl/tri3d_cell_geometry.sv
`timescale 1ns / 1ps
// Top level: linear 3D triangle mapping, Jacobian and area factor pipeline.
//
// Usage:
//   Drive the three vertices, the reference point and last flag on the in_
//   ports and pulse start; a transaction is taken at each rising edge with
//   start high and busy low. busy is always low, so a new point may enter
//   every cycle and the sustained rate is one point per clock.
//   Each result appears on the out_ ports for one cycle with out_valid high,
//   once the point has passed from the input register through one edge stage,
//   six cross-product and squaring stages, 48 square-root stages (one result
//   bit each) and the output register.
//   Results leave in the order points entered. The receiver cannot stall the
//   block; the pipeline never holds.
//   Reset (rst_n low at a clock edge) clears all valid bits, so no strobe
//   appears for points in flight; the datapath keeps no other state.
module tri3d_cell_geometry (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tcg_pkg::coord_t      in_ax,
  input  tcg_pkg::coord_t      in_ay,
  input  tcg_pkg::coord_t      in_az,
  input  tcg_pkg::coord_t      in_bx,
  input  tcg_pkg::coord_t      in_by_coord,
  input  tcg_pkg::coord_t      in_bz,
  input  tcg_pkg::coord_t      in_cx,
  input  tcg_pkg::coord_t      in_cy,
  input  tcg_pkg::coord_t      in_cz,
  input  logic signed [15:0]   in_ref_u,
  input  logic signed [15:0]   in_ref_v,
  input  logic                 in_last_in,
  output logic                 out_valid,
  output tcg_pkg::coord_t      out_gx,
  output tcg_pkg::coord_t      out_gy,
  output tcg_pkg::coord_t      out_gz,
  output tcg_pkg::coord_t      out_jac_xu,
  output tcg_pkg::coord_t      out_jac_xv,
  output tcg_pkg::coord_t      out_jac_yu,
  output tcg_pkg::coord_t      out_jac_yv,
  output tcg_pkg::coord_t      out_jac_zu,
  output tcg_pkg::coord_t      out_jac_zv,
  output logic [47:0]          out_area_scale,
  output logic                 out_last_out
);
  import tcg_pkg::*;

  localparam int MapDly = TotLat - MapLat;
  localparam int GW     = 3 * CoordW;

  logic   v0_r;
  coord_t ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic signed [RefW-1:0] u_r, w_r;
  logic   last0_r;

  logic   v1_r;
  coord_t a1x_r, a1y_r, a1z_r;
  edge_t  f1_r, g1_r, h1_r, f2_r, g2_r, h2_r;
  pref_t  pu_r, pv_r;
  logic   last1_r;

  logic              vd_r    [0:TotLat-1];
  logic              lastd_r [0:TotLat-1];
  logic [JacW-1:0]   jacd_r  [0:TotLat-1];
  logic [GW-1:0]     gd_r    [0:MapDly-1];
  logic [JacW-1:0]   jac1;
  coord_t            gx, gy, gz;
  logic [NW-1:0]     n_area;
  logic [RootW-1:0]  root;

  logic              out_valid_r;
  logic [GW-1:0]     g_out_r;
  logic [JacW-1:0]   jac_out_r;
  logic [RootW-1:0]  area_r;
  logic              last_out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r    <= in_ax;
    ay_r    <= in_ay;
    az_r    <= in_az;
    bx_r    <= in_bx;
    by_r    <= in_by_coord;
    bz_r    <= in_bz;
    cx_r    <= in_cx;
    cy_r    <= in_cy;
    cz_r    <= in_cz;
    u_r     <= in_ref_u;
    w_r     <= in_ref_v;
    last0_r <= in_last_in;
    a1x_r   <= ax_r;
    a1y_r   <= ay_r;
    a1z_r   <= az_r;
    f1_r    <= EdgeW'(bx_r) - EdgeW'(ax_r);
    g1_r    <= EdgeW'(by_r) - EdgeW'(ay_r);
    h1_r    <= EdgeW'(bz_r) - EdgeW'(az_r);
    f2_r    <= EdgeW'(cx_r) - EdgeW'(ax_r);
    g2_r    <= EdgeW'(cy_r) - EdgeW'(ay_r);
    h2_r    <= EdgeW'(cz_r) - EdgeW'(az_r);
    pu_r    <= PW'(u_r) + PW'(1 << (RefW - 2));
    pv_r    <= PW'(w_r) + PW'(1 << (RefW - 2));
    last1_r <= last0_r;
  end

  assign jac1 = {f1_r[EdgeW-1:1], f2_r[EdgeW-1:1], g1_r[EdgeW-1:1],
                 g2_r[EdgeW-1:1], h1_r[EdgeW-1:1], h2_r[EdgeW-1:1]};

  tcg_map u_map_x (.clk(clk), .a_i(a1x_r), .e1_i(f1_r), .e2_i(f2_r),
                   .pu_i(pu_r), .pv_i(pv_r), .g_o(gx));
  tcg_map u_map_y (.clk(clk), .a_i(a1y_r), .e1_i(g1_r), .e2_i(g2_r),
                   .pu_i(pu_r), .pv_i(pv_r), .g_o(gy));
  tcg_map u_map_z (.clk(clk), .a_i(a1z_r), .e1_i(h1_r), .e2_i(h2_r),
                   .pu_i(pu_r), .pv_i(pv_r), .g_o(gz));

  tcg_area u_area (.clk(clk), .f1_i(f1_r), .g1_i(g1_r), .h1_i(h1_r),
                   .f2_i(f2_r), .g2_i(g2_r), .h2_i(h2_r), .n_o(n_area));

  tcg_sqrt u_sqrt (.clk(clk), .n_i(n_area), .root_o(root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TotLat; i++) begin
        vd_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vd_r[0] <= v1_r;
      for (int i = 1; i < TotLat; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      out_valid_r <= vd_r[TotLat-1];
    end
  end

  always_ff @(posedge clk) begin
    lastd_r[0] <= last1_r;
    jacd_r[0]  <= jac1;
    for (int i = 1; i < TotLat; i++) begin
      lastd_r[i] <= lastd_r[i-1];
      jacd_r[i]  <= jacd_r[i-1];
    end
    gd_r[0] <= {gx, gy, gz};
    for (int i = 1; i < MapDly; i++) begin
      gd_r[i] <= gd_r[i-1];
    end
    g_out_r    <= gd_r[MapDly-1];
    jac_out_r  <= jacd_r[TotLat-1];
    area_r     <= root;
    last_out_r <= lastd_r[TotLat-1];
  end

  assign out_valid      = out_valid_r;
  assign out_gx         = g_out_r[3*CoordW-1:2*CoordW];
  assign out_gy         = g_out_r[2*CoordW-1:CoordW];
  assign out_gz         = g_out_r[CoordW-1:0];
  assign out_jac_xu     = jac_out_r[6*CoordW-1:5*CoordW];
  assign out_jac_xv     = jac_out_r[5*CoordW-1:4*CoordW];
  assign out_jac_yu     = jac_out_r[4*CoordW-1:3*CoordW];
  assign out_jac_yv     = jac_out_r[3*CoordW-1:2*CoordW];
  assign out_jac_zu     = jac_out_r[2*CoordW-1:CoordW];
  assign out_jac_zv     = jac_out_r[CoordW-1:0];
  assign out_area_scale = area_r;
  assign out_last_out   = last_out_r;

endmodule
